// ===== rtl/exclusive_group_task_dispatcher_defines.svh =====
// assertion macros used by the dispatcher back end
`ifndef EXCLUSIVE_GROUP_TASK_DISPATCHER_DEFINES_SVH
`define EXCLUSIVE_GROUP_TASK_DISPATCHER_DEFINES_SVH

// condition holds on every edge out of reset
`define EGTD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent holds on the edge after antecedent
`define EGTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/egtd_pkg.sv =====
// types and codes of the exclusive group task dispatcher
package egtd_pkg;

  localparam int unsigned FuncW  = 2;
  localparam int unsigned GroupW = 4;
  localparam int unsigned TagW   = 16;
  localparam int unsigned QcntW  = 5;
  localparam int unsigned AcntW  = 4;

  localparam logic [FuncW-1:0] FUNC_ENQ    = 2'd0;
  localparam logic [FuncW-1:0] FUNC_DISP   = 2'd1;
  localparam logic [FuncW-1:0] FUNC_DONE   = 2'd2;
  localparam logic [FuncW-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [GroupW-1:0] group_index;
    logic              is_exclusive;
    logic [TagW-1:0]   task_tag;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic [TagW-1:0]   grant_tag;
    logic [GroupW-1:0] grant_group;
    logic              grant_exclusive;
    logic [QcntW-1:0]  queued_count;
    logic [AcntW-1:0]  active_count;
    logic              all_idle;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_DISP,
    OP_DONE,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              group_ok;
    logic [GroupW-1:0] group;
    logic              excl;
    logic [TagW-1:0]   tag;
  } cmd_t;

endpackage

// ===== rtl/egtd_front.sv =====
// front stage: takes input beats and classifies them into commands
module egtd_front #(
  parameter int unsigned GROUP_COUNT = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  egtd_pkg::in_item_t in_data_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output egtd_pkg::cmd_t    cmd_o
);
  import egtd_pkg::*;

  logic hold_q;
  cmd_t cmd_q, cmd_d;

  always_comb begin
    cmd_d.group    = in_data_i.group_index;
    cmd_d.excl     = in_data_i.is_exclusive;
    cmd_d.tag      = in_data_i.task_tag;
    cmd_d.group_ok = (int'(in_data_i.group_index) < GROUP_COUNT);
    case (in_data_i.func)
      FUNC_ENQ:  cmd_d.op = OP_ENQ;
      FUNC_DISP: cmd_d.op = OP_DISP;
      FUNC_DONE: cmd_d.op = OP_DONE;
      default:   cmd_d.op = OP_NOP;
    endcase
  end

  assign in_ready_o  = !hold_q || cmd_ready_i;
  assign cmd_valid_o = hold_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else if (in_ready_o) begin
      hold_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// ===== rtl/egtd_fifo.sv =====
// two-entry command queue between front and back
module egtd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  egtd_pkg::cmd_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output egtd_pkg::cmd_t rd_data_o
);
  import egtd_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== rtl/egtd_core.sv =====
// back stage: task queue, group locks, worker count and result register
module egtd_core #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned GROUP_COUNT = 16,
  parameter int unsigned WORKERS     = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  egtd_pkg::cmd_t     cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output egtd_pkg::out_item_t out_data_o
);
  import egtd_pkg::*;

  `include "exclusive_group_task_dispatcher_defines.svh"

  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = $clog2(WORKERS + 1);

  typedef enum logic {ST_IDLE, ST_SCAN} state_e;

  state_e                  state_q;
  cmd_t                    cur_q;
  logic [TagW-1:0]         ent_tag_q   [QUEUE_DEPTH];
  logic [GroupW-1:0]       ent_group_q [QUEUE_DEPTH];
  logic                    ent_excl_q  [QUEUE_DEPTH];
  logic [FW-1:0]           fill_q, fill_d;
  logic [AW-1:0]           active_q, active_d;
  logic [GROUP_COUNT-1:0]  busy_q, busy_d;
  logic [QUEUE_DEPTH-1:0]  elig_q, elig_d, first, tail;
  logic                    out_valid_q;
  out_item_t               out_q, res;
  logic                    slot_free, pop, commit, enq_wr, shift;
  logic [TagW-1:0]         g_tag;
  logic [GroupW-1:0]       g_group;
  logic                    g_excl;

  function automatic logic busy_at(logic [GROUP_COUNT-1:0] b, logic [GroupW-1:0] g);
    logic r;
    r = 1'b0;
    for (int k = 0; k < GROUP_COUNT; k++) begin
      if (int'(g) == k) r = b[k];
    end
    return r;
  endfunction

  assign slot_free   = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == ST_IDLE) && slot_free;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // eligibility of every slot, taken at the cycle the dispatch is popped
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      elig_d[i] = (i < int'(fill_q)) &&
                  (!ent_excl_q[i] || !busy_at(busy_q, ent_group_q[i]));
    end
  end

  // oldest eligible slot and everything at or behind it
  assign first = elig_q & (~elig_q + QUEUE_DEPTH'(1));
  assign tail  = ~(first - QUEUE_DEPTH'(1));

  always_comb begin
    g_tag   = '0;
    g_group = '0;
    g_excl  = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      g_tag   = g_tag   | (ent_tag_q[i]   & {TagW{first[i]}});
      g_group = g_group | (ent_group_q[i] & {GroupW{first[i]}});
      g_excl  = g_excl  | (ent_excl_q[i]  & first[i]);
    end
  end

  always_comb begin
    fill_d   = fill_q;
    active_d = active_q;
    busy_d   = busy_q;
    commit   = 1'b0;
    enq_wr   = 1'b0;
    shift    = 1'b0;
    res      = '0;
    if (state_q == ST_SCAN) begin
      commit = 1'b1;
      if ((active_q < AW'(WORKERS)) && (|elig_q)) begin
        shift              = 1'b1;
        fill_d             = fill_q - FW'(1);
        active_d           = active_q + AW'(1);
        res.accepted       = 1'b1;
        res.grant_tag      = g_tag;
        res.grant_group    = g_group;
        res.grant_exclusive = g_excl;
        for (int k = 0; k < GROUP_COUNT; k++) begin
          if (g_excl && int'(g_group) == k) busy_d[k] = 1'b1;
        end
      end
    end else if (pop) begin
      case (cmd_i.op)
        OP_ENQ: begin
          commit = 1'b1;
          if ((fill_q < FW'(QUEUE_DEPTH)) && (!cmd_i.excl || cmd_i.group_ok)) begin
            enq_wr       = 1'b1;
            fill_d       = fill_q + FW'(1);
            res.accepted = 1'b1;
          end
        end
        OP_DONE: begin
          commit = 1'b1;
          if ((active_q != '0) &&
              (!cmd_i.excl || (cmd_i.group_ok && busy_at(busy_q, cmd_i.group)))) begin
            active_d     = active_q - AW'(1);
            res.accepted = 1'b1;
            for (int k = 0; k < GROUP_COUNT; k++) begin
              if (cmd_i.excl && int'(cmd_i.group) == k) busy_d[k] = 1'b0;
            end
          end
        end
        OP_DISP: commit = 1'b0;
        default: commit = 1'b1;
      endcase
    end
    res.queued_count = QcntW'(fill_d);
    res.active_count = AcntW'(active_d);
    res.all_idle     = (fill_d == '0) && (active_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      active_q    <= '0;
      busy_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      active_q <= active_d;
      busy_q   <= busy_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: if (pop && cmd_i.op == OP_DISP) state_q <= ST_SCAN;
        ST_SCAN: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q  <= cmd_i;
      elig_q <= elig_d;
    end
    if (commit) begin
      out_q <= res;
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (shift && tail[i] && (i < QUEUE_DEPTH - 1)) begin
        ent_tag_q[i]   <= ent_tag_q[(i + 1) % QUEUE_DEPTH];
        ent_group_q[i] <= ent_group_q[(i + 1) % QUEUE_DEPTH];
        ent_excl_q[i]  <= ent_excl_q[(i + 1) % QUEUE_DEPTH];
      end else if (enq_wr && int'(fill_q) == i) begin
        ent_tag_q[i]   <= cmd_i.tag;
        ent_group_q[i] <= cmd_i.group;
        ent_excl_q[i]  <= cmd_i.excl;
      end
    end
  end

  `EGTD_ASSERT_ALWAYS(a_fill_bound, fill_q <= FW'(QUEUE_DEPTH), "queue fill beyond depth")
  `EGTD_ASSERT_ALWAYS(a_active_bound, active_q <= AW'(WORKERS), "workers beyond limit")
  `EGTD_ASSERT_NEXT(a_disp_scans, pop && cmd_i.op == OP_DISP, state_q == ST_SCAN && cur_q.op == OP_DISP, "dispatch did not scan")
  `EGTD_ASSERT_ALWAYS(a_no_overwrite, !(commit && out_valid_q && !out_ready_i), "result overwritten")

endmodule

// ===== rtl/exclusive_group_task_dispatcher.sv =====
// top level of the exclusive group task dispatcher
// Ordered task queue with one lock per exclusivity group. An enqueue appends a task, a dispatch
// grants the oldest task that is non-exclusive or whose group is free, given a free worker; a
// completion releases the lock and one worker; every beat returns exactly one result beat. Beats
// pass a front register that decodes the function code and range-checks the group, then a
// two-entry command queue, then the back end that owns the queue and locks. Enqueue, completion
// and unused codes are handled in its idle state; a dispatch latches every slot's eligibility
// there, then picks the oldest eligible slot with a priority pick and closes the gap by shifting
// the younger slots down. Results sit in an output register; while one waits the back end stalls
// and beats back up into the command queue. No clearing pass is needed after reset.
module exclusive_group_task_dispatcher #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned GROUP_COUNT = 16,
  parameter int unsigned WORKERS     = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  egtd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output egtd_pkg::out_item_t out_data_o
);
  import egtd_pkg::*;

  // front to queue
  logic f_valid, f_ready;
  cmd_t f_cmd;
  // queue to back end
  logic b_valid, b_ready;
  cmd_t b_cmd;

  egtd_front #(.GROUP_COUNT(GROUP_COUNT)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_data_i,
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd)
  );

  egtd_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_cmd),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_cmd)
  );

  egtd_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH), .GROUP_COUNT(GROUP_COUNT), .WORKERS(WORKERS)
  ) u_core (
    .clk_i, .rst_ni,
    .cmd_valid_i(b_valid), .cmd_ready_o(b_ready), .cmd_i(b_cmd),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
